@@ hw/rtl/mf2d_pkg.sv @@
// ----------------------------------------------------------------------------
// mf2d_pkg
// shared types and constants of the 2-d median filter
// ----------------------------------------------------------------------------
package mf2d_pkg;

  localparam int PIX_W    = 8;
  localparam int NUM_CH   = 3;
  localparam int KS_W     = 3;
  localparam int FW_W     = 11;
  localparam int FH_W     = 13;
  localparam int ROW_W    = 12;
  localparam int MAX_ROWS = 4096;
  localparam int PIX_MAX  = 255;

  localparam logic [KS_W-1:0] KS_RST = 3'd3;
  localparam logic [FW_W-1:0] FW_RST = 11'd640;
  localparam logic [FH_W-1:0] FH_RST = 13'd480;

  typedef enum logic [1:0] {
    REG_KERNEL = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_COLOR  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic clear;
    logic push;
  } lane_ctl_t;

endpackage

@@ hw/rtl/mf2d_store.sv @@
// ----------------------------------------------------------------------------
// mf2d_store
// circular pixel store, one write and one registered read port
// ----------------------------------------------------------------------------
module mf2d_store #(
  parameter int DEPTH = 7168,
  parameter int AW    = 13,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ hw/rtl/mf2d_lane.sv @@
// ----------------------------------------------------------------------------
// mf2d_lane
// one channel lane: insertion sorter over the window and middle pick
// ----------------------------------------------------------------------------
module mf2d_lane #(
  parameter int CAP = 49
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mf2d_pkg::lane_ctl_t         ctl,
  input  logic [mf2d_pkg::PIX_W-1:0]  din,
  output logic [mf2d_pkg::PIX_W-1:0]  med
);

  localparam int NW = $clog2(CAP + 1);
  localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;

  logic [mf2d_pkg::PIX_W-1:0] buf_r [CAP];
  logic [mf2d_pkg::PIX_W-1:0] buf_nxt [CAP];
  logic [CAP-1:0]             le;
  logic [NW-1:0]              n_r;
  logic [NW-1:0]              lo_n;
  logic [IW-1:0]              lo_idx;
  logic [IW-1:0]              hi_idx;
  logic [mf2d_pkg::PIX_W:0]   sum;

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      le[i] = (NW'(i) < n_r) && (buf_r[i] <= din);
    end
    buf_nxt[0] = le[0] ? buf_r[0] : din;
    for (int i = 1; i < CAP; i++) begin
      if (le[i]) begin
        buf_nxt[i] = buf_r[i];
      end else if (le[i-1]) begin
        buf_nxt[i] = din;
      end else begin
        buf_nxt[i] = buf_r[i-1];
      end
    end
    lo_n   = (n_r - NW'(1)) >> 1;
    lo_idx = lo_n[IW-1:0];
    hi_idx = IW'(n_r >> 1);
    sum    = {1'b0, buf_r[lo_idx]} + {1'b0, buf_r[hi_idx]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (ctl.clear) begin
      n_r <= '0;
    end else if (ctl.push && (n_r < NW'(CAP))) begin
      n_r <= n_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear && (n_r < NW'(CAP))) begin
      for (int i = 0; i < CAP; i++) begin
        buf_r[i] <= buf_nxt[i];
      end
    end
    med <= sum[mf2d_pkg::PIX_W:1];
  end

endmodule

@@ hw/rtl/median_filter_2d.sv @@
// ----------------------------------------------------------------------------
// median_filter_2d
// streaming k-by-k median filter, three channel lanes over a pixel store
// ----------------------------------------------------------------------------
// channel | ports                          | role
// in      | in_valid/in_ready, in_*        | pixel or drain beat
// out     | out_valid/out_ready, out_*     | filtered pixel beat
// cfg     | cfg_psel ... cfg_pready        | register write and read
// a beat that releases no result goes from idle through the check state back to idle
// a beat that releases a result walks the window in the sweep state through the
//   single store read port one pixel a cycle, then the last, median and finish states
// the output register holds a result while the next beat is taken
// reset restores the register defaults and empties the positions
// ----------------------------------------------------------------------------
module median_filter_2d #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_chan0_in,
  input  logic [7:0]  in_chan1_in,
  input  logic [7:0]  in_chan2_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_chan0_out,
  output logic [7:0]  out_chan1_out,
  output logic [7:0]  out_chan2_out,
  output logic        out_frame_end,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int D    = MAX_KERNEL * MAX_WIDTH;
  localparam int AW   = $clog2(D);
  localparam int SW   = AW + 2;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int NCW  = WW + 2;
  localparam int CAP  = MAX_KERNEL * MAX_KERNEL;
  localparam int RMAX = (MAX_KERNEL - 1) / 2;
  localparam int PW   = mf2d_pkg::PIX_W;
  localparam int RW   = mf2d_pkg::ROW_W;
  localparam int FHW  = mf2d_pkg::FH_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SWEEP, S_LAST, S_MED, S_FIN
  } state_t;

  function automatic logic [AW-1:0] wrap(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v;
    if (t < 0) begin
      t = t + SW'(D);
    end else if (t >= SW'(D)) begin
      t = t - SW'(D);
    end
    return t[AW-1:0];
  endfunction

  state_t                      state_r;
  logic [mf2d_pkg::KS_W-1:0]   ks_r;
  logic [mf2d_pkg::FW_W-1:0]   fw_r;
  logic [FHW-1:0]              fh_r;
  logic                        cm_r;
  logic [CW-1:0]               in_col_r;
  logic [RW-1:0]               in_row_r;
  logic [AW-1:0]               in_addr_r;
  logic [CW-1:0]               out_col_r;
  logic [RW-1:0]               out_row_r;
  logic [AW-1:0]               out_addr_r;
  logic                        behind_r;
  logic signed [2:0]           dr_r;
  logic signed [2:0]           dc_r;
  logic [AW-1:0]               rs_r;
  logic                        rd_v_r;
  logic                        out_valid_r;
  logic [PW-1:0]               out_c0_r;
  logic [PW-1:0]               out_c1_r;
  logic [PW-1:0]               out_c2_r;
  logic                        out_fe_r;

  logic [WW-1:0]               w_eff;
  logic [FHW-1:0]              h_eff;
  logic [1:0]                  r_eff;
  logic signed [2:0]           r_s;
  logic [FHW-1:0]              lr;
  logic [WW:0]                 lc;
  logic                        ready_now;
  logic signed [RW+1:0]        nr;
  logic signed [NCW-1:0]       nc;
  logic                        pos_ok;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               rs_init;
  logic [SW-1:0]               rw_prod;
  logic                        in_acc;
  logic                        cfg_wr;
  mf2d_pkg::reg_idx_t          cfg_idx;
  logic [3*PW-1:0]             rd_data;
  logic [PW-1:0]               med [mf2d_pkg::NUM_CH];
  mf2d_pkg::lane_ctl_t         lane_ctl;
  logic                        in_col_end;
  logic                        in_row_end;
  logic                        out_col_end;
  logic                        out_row_end;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = mf2d_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_chan0_out = out_c0_r;
  assign out_chan1_out = out_c1_r;
  assign out_chan2_out = out_c2_r;
  assign out_frame_end = out_fe_r;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        mf2d_pkg::REG_KERNEL: cfg_prdata = 32'(ks_r);
        mf2d_pkg::REG_WIDTH:  cfg_prdata = 32'(fw_r);
        mf2d_pkg::REG_HEIGHT: cfg_prdata = 32'(fh_r);
        mf2d_pkg::REG_COLOR:  cfg_prdata = 32'(cm_r);
        default:              cfg_prdata = '0;
      endcase
    end
  end

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = FHW'(1);
    end else if (32'(fh_r) > 32'(mf2d_pkg::MAX_ROWS)) begin
      h_eff = FHW'(mf2d_pkg::MAX_ROWS);
    end else begin
      h_eff = fh_r;
    end
    if (!ks_r[0]) begin
      r_eff = 2'd0;
    end else if (32'(ks_r >> 1) > 32'(RMAX)) begin
      r_eff = 2'(RMAX);
    end else begin
      r_eff = 2'(ks_r >> 1);
    end
    r_s = $signed({1'b0, r_eff});

    lr = FHW'(out_row_r) + FHW'(r_eff);
    if (lr > h_eff - FHW'(1)) lr = h_eff - FHW'(1);
    lc = (WW+1)'(out_col_r) + (WW+1)'(r_eff);
    if (lc > (WW+1)'(w_eff) - (WW+1)'(1)) lc = (WW+1)'(w_eff) - (WW+1)'(1);
    ready_now = behind_r || (lr < FHW'(in_row_r)) ||
                ((lr == FHW'(in_row_r)) && (lc < (WW+1)'(in_col_r)));

    nr = $signed({2'b00, out_row_r}) + (RW+2)'(dr_r);
    nc = $signed(NCW'(out_col_r)) + NCW'(dc_r);
    pos_ok = (nr >= 0) && (nr < $signed({1'b0, h_eff})) &&
             (nc >= 0) && (nc < $signed(NCW'(w_eff)));
    rd_addr = wrap($signed(SW'(rs_r)) + SW'(dc_r));
    rw_prod = SW'(r_eff) * SW'(w_eff);
    rs_init = wrap($signed(SW'(out_addr_r)) - $signed(rw_prod));

    in_col_end  = (WW'(in_col_r) + WW'(1)) >= w_eff;
    in_row_end  = (FHW'(in_row_r) + FHW'(1)) >= h_eff;
    out_col_end = (WW'(out_col_r) + WW'(1)) >= w_eff;
    out_row_end = (FHW'(out_row_r) + FHW'(1)) >= h_eff;

    lane_ctl.clear = (state_r == S_CHECK);
    lane_ctl.push  = rd_v_r;
  end

  mf2d_store #(
    .DEPTH (D),
    .AW    (AW),
    .DW    (3*PW)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && !in_mode),
    .waddr (in_addr_r),
    .wdata ({in_chan2_in, in_chan1_in, in_chan0_in}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  for (genvar g = 0; g < mf2d_pkg::NUM_CH; g++) begin : g_lane
    mf2d_lane #(
      .CAP (CAP)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .din   (rd_data[g*PW +: PW]),
      .med   (med[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ks_r        <= mf2d_pkg::KS_RST;
      fw_r        <= mf2d_pkg::FW_RST;
      fh_r        <= mf2d_pkg::FH_RST;
      cm_r        <= 1'b1;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_addr_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_addr_r  <= '0;
      behind_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= (state_r == S_SWEEP) && pos_ok;
      if (out_valid_r && out_ready && (state_r != S_FIN)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (!in_mode) begin
              in_addr_r <= (32'(in_addr_r) == D - 1) ? '0 : in_addr_r + AW'(1);
              if (in_col_end) begin
                in_col_r <= '0;
                if (in_row_end) begin
                  in_row_r <= '0;
                  behind_r <= 1'b1;
                end else begin
                  in_row_r <= in_row_r + RW'(1);
                end
              end else begin
                in_col_r <= in_col_r + CW'(1);
              end
            end
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ready_now) begin
            dr_r    <= -r_s;
            dc_r    <= -r_s;
            rs_r    <= rs_init;
            state_r <= S_SWEEP;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (dc_r == r_s) begin
            if (dr_r == r_s) begin
              state_r <= S_LAST;
            end else begin
              dr_r <= dr_r + 3'sd1;
              dc_r <= -r_s;
              rs_r <= wrap($signed(SW'(rs_r)) + $signed(SW'(w_eff)));
            end
          end else begin
            dc_r <= dc_r + 3'sd1;
          end
        end
        S_LAST: state_r <= S_MED;
        S_MED:  state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_c0_r    <= med[0];
            out_c1_r    <= cm_r ? med[1] : '0;
            out_c2_r    <= cm_r ? med[2] : '0;
            out_fe_r    <= out_col_end && out_row_end;
            out_addr_r  <= (32'(out_addr_r) == D - 1) ? '0 : out_addr_r + AW'(1);
            if (out_col_end) begin
              out_col_r <= '0;
              if (out_row_end) begin
                out_row_r <= '0;
                behind_r  <= 1'b0;
              end else begin
                out_row_r <= out_row_r + RW'(1);
              end
            end else begin
              out_col_r <= out_col_r + CW'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_wr) begin
        case (cfg_idx)
          mf2d_pkg::REG_KERNEL: ks_r <= cfg_pwdata[mf2d_pkg::KS_W-1:0];
          mf2d_pkg::REG_WIDTH:  fw_r <= cfg_pwdata[mf2d_pkg::FW_W-1:0];
          mf2d_pkg::REG_HEIGHT: fh_r <= cfg_pwdata[FHW-1:0];
          mf2d_pkg::REG_COLOR:  cm_r <= cfg_pwdata[0];
          default:              cm_r <= cm_r;
        endcase
        in_col_r   <= '0;
        in_row_r   <= '0;
        in_addr_r  <= '0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        out_addr_r <= '0;
        behind_r   <= 1'b0;
      end
    end
  end

  a_push_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == S_SWEEP || state_r == S_LAST))
    else $error("lane push outside window walk");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("result load lost");

  a_in_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(in_addr_r) < D) && (32'(out_addr_r) < D))
    else $error("store address out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> !in_ready)
    else $error("beat taken during window walk");

endmodule

@@ tb/sv/median_filter_2d_test.sv @@
// ----------------------------------------------------------------------------
// median_filter_2d_test
// self-checking bench for the streaming k-by-k median filter: a local
// predictor computes the expected filtered pixels for every accepted beat,
// a driver and a monitor move beats with random gaps, and frames of many
// geometries, kernels and color modes run between register writes
// ----------------------------------------------------------------------------
module median_filter_2d_test;

  localparam int DEPTH = 7 * 1024;
  localparam int LIMIT = 4000000;

  typedef struct {
    bit         mode;
    logic [7:0] c0, c1, c2;
  } beat_t;

  typedef struct {
    logic [7:0] c0, c1, c2;
    logic       fe;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic [7:0]  in_chan0_in = '0, in_chan1_in = '0, in_chan2_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_chan0_out, out_chan1_out, out_chan2_out;
  logic        out_frame_end;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  median_filter_2d dut (.*);

  beat_t  beat_q[$];
  pixel_t pixel_q[$];
  int     errors = 0, beats_sent = 0, pixels_seen = 0, frames_run = 0;
  int     cycles = 0, tx_gap = 0, rx_gap = 0, g;
  bit     calm = 1'b0, rx_hold = 1'b0, hold_req = 1'b0;

  // predictor state
  logic [23:0] pix_store[DEPTH];
  int  ks = mf2d_pkg::KS_RST, fw = mf2d_pkg::FW_RST, fh = mf2d_pkg::FH_RST, cm = 1;
  int  irow, icol, orow, ocol, ibase, obase;
  bit  behind;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("median_filter_2d: mismatch");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report(input string what);
    errors++;
    $display("error at result %0d: %s", pixels_seen, what);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) beats_sent <= beats_sent + 1;
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          beat_t b;
          b = beat_q.pop_front();
          in_mode <= b.mode;
          in_chan0_in <= b.c0;
          in_chan1_in <= b.c1;
          in_chan2_in <= b.c2;
          in_valid <= 1'b1;
          tx_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          report("unexpected beat");
        end else begin
          pixel_t e;
          e = pixel_q.pop_front();
          if (out_chan0_out !== e.c0)
            report($sformatf("chan0 %0h want %0h", out_chan0_out, e.c0));
          if (out_chan1_out !== e.c1)
            report($sformatf("chan1 %0h want %0h", out_chan1_out, e.c1));
          if (out_chan2_out !== e.c2)
            report($sformatf("chan2 %0h want %0h", out_chan2_out, e.c2));
          if (out_frame_end !== e.fe)
            report($sformatf("frame_end %0b want %0b", out_frame_end, e.fe));
        end
        pixels_seen <= pixels_seen + 1;
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else begin
        g = (out_valid && out_ready) ? gap_len() : 0;
        if (g > 0) begin
          rx_gap <= g;
          out_ready <= 1'b0;
        end else begin
          out_ready <= !rx_hold;
        end
      end
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (600) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic int geo_w();
    return (fw == 0) ? 1 : (fw > 1024 ? 1024 : fw);
  endfunction

  function automatic int geo_h();
    return (fh == 0) ? 1 : (fh > mf2d_pkg::MAX_ROWS ? mf2d_pkg::MAX_ROWS : fh);
  endfunction

  function automatic int win_radius();
    if (ks % 2 == 0) return 0;
    return (ks / 2 > 3) ? 3 : ks / 2;
  endfunction

  function automatic logic [7:0] window_median(int ch, int r, int w, int h);
    int vals[49];
    int n = 0, i, v, nr, nc;
    for (int dr = -r; dr <= r; dr++) begin
      nr = orow + dr;
      if (nr < 0 || nr >= h) continue;
      for (int dc = -r; dc <= r; dc++) begin
        nc = ocol + dc;
        if (nc < 0 || nc >= w) continue;
        v = (pix_store[(obase + nr * w + nc) % DEPTH] >> (8 * ch)) & 8'hff;
        i = n;
        while (i > 0 && vals[i-1] > v) begin
          vals[i] = vals[i-1];
          i--;
        end
        vals[i] = v;
        n++;
      end
    end
    if (n == 0) return 8'd0;
    if (n % 2 == 1) return 8'(vals[n/2]);
    return 8'((vals[n/2-1] + vals[n/2]) >> 1);
  endfunction

  task automatic filter_step(input bit md, input logic [7:0] a, b, c, output bit hit);
    int w, h, fr, r, lr, lc;
    pixel_t e;
    w = geo_w();
    h = geo_h();
    fr = (w * h) % DEPTH;
    r = win_radius();
    if (!md) begin
      pix_store[(ibase + irow * w + icol) % DEPTH] = {c, b, a};
      icol++;
      if (icol >= w) begin
        icol = 0;
        irow++;
        if (irow >= h) begin
          irow = 0;
          ibase = (ibase + fr) % DEPTH;
          behind = 1'b1;
        end
      end
    end
    if (behind) begin
      hit = 1'b1;
    end else begin
      lr = (orow + r > h - 1) ? h - 1 : orow + r;
      lc = (ocol + r > w - 1) ? w - 1 : ocol + r;
      hit = (lr * w + lc) < (irow * w + icol);
    end
    if (!hit) return;
    e.c0 = window_median(0, r, w, h);
    e.c1 = cm ? window_median(1, r, w, h) : 8'd0;
    e.c2 = cm ? window_median(2, r, w, h) : 8'd0;
    e.fe = (orow == h - 1 && ocol == w - 1);
    pixel_q.insert(pixel_q.size(), e);
    ocol++;
    if (ocol >= w) begin
      ocol = 0;
      orow++;
      if (orow >= h) begin
        orow = 0;
        obase = (obase + fr) % DEPTH;
        behind = 1'b0;
      end
    end
  endtask

  task automatic push_beat(input bit md, input logic [7:0] a, b, c, output bit hit);
    beat_t bt;
    filter_step(md, a, b, c, hit);
    bt.mode = md;
    bt.c0 = a;
    bt.c1 = b;
    bt.c2 = c;
    beat_q.insert(beat_q.size(), bt);
  endtask

  task automatic push_pixel(input logic [7:0] a, b, c);
    bit hit;
    push_beat(1'b0, a, b, c, hit);
  endtask

  task automatic push_random_pixel();
    push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain_all();
    bit hit;
    do push_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), hit); while (hit);
  endtask

  task automatic wait_idle();
    wait (beat_q.size() == 0 && !in_valid);
    wait (pixel_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic reg_write(input mf2d_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      mf2d_pkg::REG_KERNEL: ks = val & 32'h7;
      mf2d_pkg::REG_WIDTH:  fw = val & 32'h7ff;
      mf2d_pkg::REG_HEIGHT: fh = val & 32'h1fff;
      mf2d_pkg::REG_COLOR:  cm = val & 32'h1;
      default:              cm = cm;
    endcase
    irow = 0; icol = 0; orow = 0; ocol = 0;
    ibase = 0; obase = 0; behind = 1'b0;
  endtask

  task automatic setup(input int k, input int w, input int h, input int color);
    wait_idle();
    reg_write(mf2d_pkg::REG_KERNEL, k);
    reg_write(mf2d_pkg::REG_WIDTH, w);
    reg_write(mf2d_pkg::REG_HEIGHT, h);
    reg_write(mf2d_pkg::REG_COLOR, color);
    calm = ($urandom_range(0, 4) == 0);
  endtask

  task automatic drain_all_one();
    bit hit;
    push_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), hit);
  endtask

  task automatic random_frame();
    int n;
    n = geo_w() * geo_h();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) drain_all_one();
      push_random_pixel();
    end
    frames_run++;
  endtask

  initial begin
    irow = 0; icol = 0; orow = 0; ocol = 0;
    ibase = 0; obase = 0; behind = 1'b0;
    foreach (pix_store[i]) pix_store[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // default kernel and color mode, small frame of extreme values
    setup(3, 4, 3, 1);
    for (int i = 0; i < 12; i++)
      push_pixel((i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h00 : 8'hff, 8'(i * 37));
    drain_all();
    // gray mode ignores lanes 1 and 2
    setup(5, 3, 3, 0);
    for (int i = 0; i < 5; i++) push_pixel(8'($urandom), 8'hff, 8'hff);
    // sender pauses until everything expected is out
    wait_idle();
    for (int i = 0; i < 4; i++) push_pixel(8'($urandom), 8'hff, 8'hff);
    drain_all();
    // even kernel passes through, largest kernel on a single pixel
    setup(0, 2, 2, 1);
    random_frame();
    drain_all();
    setup(7, 1, 1, 1);
    random_frame();
    random_frame();
    drain_all();
    // truncated frame dropped by a register write
    setup(7, 5, 5, 1);
    for (int i = 0; i < 9; i++) push_random_pixel();

    // saturated geometry
    setup(7, 2047, 1, 1);
    random_frame();
    drain_all();
    setup(1, 1, 8191, 0);
    for (int i = 0; i < 150; i++) push_random_pixel();
    drain_all();
    setup(6, 0, 0, 1);
    random_frame();
    drain_all();

    // random frames, with one long receiver stall early on
    setup(3, 16, 8, 1);
    hold_req = 1'b1;
    random_frame();
    drain_all();
    while (beats_sent + beat_q.size() < 2000) begin
      setup($urandom_range(0, 7), $urandom_range(1, 12), $urandom_range(1, 10),
            $urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) begin
        for (int i = $urandom_range(1, 20); i > 0; i--) push_random_pixel();
      end else begin
        for (int f = $urandom_range(1, 3); f > 0; f--) random_frame();
        drain_all();
      end
    end

    wait_idle();
    $display("%0d beats in, %0d filtered pixels out, %0d frames", beats_sent, pixels_seen,
             frames_run);
    $display("kernels 0 to 7, gray and color, widths 1 to 1024, saturated size registers");
    if (errors == 0)
      $display("median_filter_2d: match");
    else
      $display("median_filter_2d: mismatch");
    $finish;
  end

endmodule
